// ===== hdl/cdt_pkg.sv =====
// Shared types and constants for the countdown timer with display multiplexing.
// Used by the knob scaler, the timer core and the top level.
package cdt_pkg;

    localparam logic [1:0] OP_DISPLAY = 2'd0;
    localparam logic [1:0] OP_SECOND  = 2'd1;
    localparam logic [1:0] OP_BUTTON  = 2'd2;
    localparam logic [1:0] OP_KNOB    = 2'd3;

    localparam logic [3:0] SEL_SEC_ONES = 4'b0001;
    localparam logic [3:0] SEL_SEC_TENS = 4'b0010;
    localparam logic [3:0] SEL_MIN_ONES = 4'b0100;
    localparam logic [3:0] SEL_MIN_TENS = 4'b1000;

    localparam logic [11:0] RESET_TIME = 12'd945;
    localparam logic [5:0]  KNOB_GAIN  = 6'd59;
    localparam logic [7:0]  TENS_RECIP = 8'd205;
    localparam logic [3:0]  DIGIT_BASE = 4'd10;
    localparam logic [3:0]  DIGIT_MAX  = 4'd9;
    localparam logic [3:0]  TENS_MAX   = 4'd5;

    typedef struct packed {
        logic [3:0] min_tens;
        logic [3:0] min_ones;
        logic [3:0] sec_tens;
        logic [3:0] sec_ones;
    } bcd_time_t;

    localparam bcd_time_t RESET_BCD = '{4'd1, 4'd5, 4'd4, 4'd5};

    typedef struct packed {
        logic [5:0] value;
        logic [3:0] tens;
        logic [3:0] ones;
    } knob_t;

    typedef struct packed {
        logic [3:0]  digit_value;
        logic [3:0]  digit_enable;
        logic        blink;
        logic        signal_out;
        logic        is_counting;
        logic [11:0] remaining;
    } result_t;

endpackage

// ===== hdl/cdt_knob_scale.sv =====
// Scales one 10-bit knob reading to 0..59 and splits it into decimal digits.
// Depends on cdt_pkg.
module cdt_knob_scale
    import cdt_pkg::*;
(
    input  logic [9:0] raw,
    output knob_t      knob
);

    logic [15:0] prod;
    logic [15:0] quot_sum;
    logic [13:0] tens_prod;
    logic [5:0]  value;
    logic [3:0]  tens;
    logic [7:0]  tens_x10;

    always_comb
    begin
        prod      = 16'(raw) * 16'(KNOB_GAIN);
        // floor(x / 1023) for every product up to 59 * 1023
        quot_sum  = prod + (prod >> 10) + 16'd1;
        value     = quot_sum[15:10];
        tens_prod = 14'(value) * 14'(TENS_RECIP);
        tens      = {1'b0, tens_prod[13:11]};
        tens_x10  = 8'(tens) * 8'(DIGIT_BASE);
        knob.value = value;
        knob.tens  = tens;
        knob.ones  = 4'(8'(value) - tens_x10);
    end

endmodule

// ===== hdl/cdt_core.sv =====
// Timer state and per-transaction update: display rotation, countdown, start/pause, knob load.
// Depends on cdt_pkg and cdt_knob_scale.
module cdt_core
    import cdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [1:0] operation,
    input  logic       button_level,
    input  logic [9:0] minutes_raw,
    input  logic [9:0] seconds_raw,
    output result_t    result
);

    logic [11:0] time_left_reg, time_left_next;
    bcd_time_t   bcd_reg, bcd_next;
    logic        counting_reg, counting_next;
    logic        at_initial_reg, at_initial_next;
    logic [3:0]  select_reg, select_next;
    logic        blink_reg, blink_next;
    logic        signal_reg, signal_next;

    knob_t       knob_min;
    knob_t       knob_sec;
    logic [3:0]  digit;
    logic [3:0]  enable;
    logic [3:0]  shifted;
    bcd_time_t   bcd_dec;

    cdt_knob_scale u_knob_min (.raw(minutes_raw), .knob(knob_min));
    cdt_knob_scale u_knob_sec (.raw(seconds_raw), .knob(knob_sec));

    always_comb
    begin
        bcd_dec = bcd_reg;
        if (bcd_reg.sec_ones != 4'd0)
        begin
            bcd_dec.sec_ones = bcd_reg.sec_ones - 4'd1;
        end
        else
        begin
            bcd_dec.sec_ones = DIGIT_MAX;
            if (bcd_reg.sec_tens != 4'd0)
            begin
                bcd_dec.sec_tens = bcd_reg.sec_tens - 4'd1;
            end
            else
            begin
                bcd_dec.sec_tens = TENS_MAX;
                if (bcd_reg.min_ones != 4'd0)
                begin
                    bcd_dec.min_ones = bcd_reg.min_ones - 4'd1;
                end
                else
                begin
                    bcd_dec.min_ones = DIGIT_MAX;
                    bcd_dec.min_tens = bcd_reg.min_tens - 4'd1;
                end
            end
        end
    end

    always_comb
    begin
        time_left_next  = time_left_reg;
        bcd_next        = bcd_reg;
        counting_next   = counting_reg;
        at_initial_next = at_initial_reg;
        select_next     = select_reg;
        blink_next      = blink_reg;
        signal_next     = signal_reg;
        digit           = 4'd0;
        enable          = 4'd0;
        shifted         = {select_reg[2:0], 1'b0};

        case (operation)
            OP_DISPLAY:
            begin
                case (select_reg)
                    SEL_SEC_ONES: digit = bcd_reg.sec_ones;
                    SEL_SEC_TENS: digit = bcd_reg.sec_tens;
                    SEL_MIN_ONES: digit = bcd_reg.min_ones;
                    SEL_MIN_TENS: digit = bcd_reg.min_tens;
                    default:      digit = 4'd0;
                endcase
                enable = select_reg;
                if (select_reg == SEL_MIN_TENS || shifted == 4'd0)
                begin
                    select_next = SEL_SEC_ONES;
                end
                else
                begin
                    select_next = shifted;
                end
            end
            OP_SECOND:
            begin
                if (counting_reg)
                begin
                    blink_next = ~blink_reg;
                    if (time_left_reg > 12'd1)
                    begin
                        time_left_next = time_left_reg - 12'd1;
                        bcd_next       = bcd_dec;
                    end
                    else
                    begin
                        time_left_next  = 12'd0;
                        bcd_next        = '0;
                        counting_next   = 1'b0;
                        at_initial_next = 1'b1;
                        signal_next     = 1'b0;
                    end
                end
                else
                begin
                    blink_next = 1'b0;
                end
            end
            OP_BUTTON:
            begin
                if (!button_level)
                begin
                    if (!counting_reg)
                    begin
                        signal_next     = 1'b1;
                        counting_next   = 1'b1;
                        at_initial_next = 1'b0;
                    end
                    else
                    begin
                        counting_next = 1'b0;
                    end
                end
            end
            default:
            begin
                if (!counting_reg && at_initial_reg)
                begin
                    time_left_next = ({6'd0, knob_min.value} << 6)
                                   - ({6'd0, knob_min.value} << 2)
                                   + {6'd0, knob_sec.value};
                    bcd_next.min_tens = knob_min.tens;
                    bcd_next.min_ones = knob_min.ones;
                    bcd_next.sec_tens = knob_sec.tens;
                    bcd_next.sec_ones = knob_sec.ones;
                end
            end
        endcase

        result.digit_value  = digit;
        result.digit_enable = enable;
        result.blink        = blink_next;
        result.signal_out   = signal_next;
        result.is_counting  = counting_next;
        result.remaining    = time_left_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_left_reg  <= RESET_TIME;
            bcd_reg        <= RESET_BCD;
            counting_reg   <= 1'b0;
            at_initial_reg <= 1'b1;
            select_reg     <= SEL_SEC_ONES;
            blink_reg      <= 1'b0;
            signal_reg     <= 1'b0;
        end
        else if (step)
        begin
            time_left_reg  <= time_left_next;
            bcd_reg        <= bcd_next;
            counting_reg   <= counting_next;
            at_initial_reg <= at_initial_next;
            select_reg     <= select_next;
            blink_reg      <= blink_next;
            signal_reg     <= signal_next;
        end
    end

endmodule

// ===== hdl/countdown_timer_mmss_display_unit.sv =====
// Countdown timer with multiplexed minutes:seconds display, top level.
// Result path: the input transaction is held in an input register, its result in a result register.
// Throughput: one transaction per cycle while the output is taken; the timer state in cdt_core updates on each step.
// Reset: asynchronous, active low; time 15:45, stopped, initial, select on seconds ones.
// Depends on cdt_pkg and cdt_core.
module countdown_timer_mmss_display_unit
    import cdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic        button_level,
    input  logic [9:0]  minutes_raw,
    input  logic [9:0]  seconds_raw,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  digit_value,
    output logic [3:0]  digit_enable,
    output logic        blink,
    output logic        signal_out,
    output logic        is_counting,
    output logic [11:0] remaining
);

    logic       in_full_reg;
    logic [1:0] op_reg;
    logic       level_reg;
    logic [9:0] min_raw_reg;
    logic [9:0] sec_raw_reg;
    logic       out_full_reg;
    result_t    result_reg;
    result_t    result;
    logic       step;

    assign step     = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready = !in_full_reg || step;

    cdt_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .operation   (op_reg),
        .button_level(level_reg),
        .minutes_raw (min_raw_reg),
        .seconds_raw (sec_raw_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_full_reg <= in_valid;
            end
            if (step)
            begin
                out_full_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg      <= operation;
            level_reg   <= button_level;
            min_raw_reg <= minutes_raw;
            sec_raw_reg <= seconds_raw;
        end
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_full_reg;
    assign digit_value  = result_reg.digit_value;
    assign digit_enable = result_reg.digit_enable;
    assign blink        = result_reg.blink;
    assign signal_out   = result_reg.signal_out;
    assign is_counting  = result_reg.is_counting;
    assign remaining    = result_reg.remaining;

endmodule

// ===== bench/tb_countdown_timer_mmss_display_unit.sv =====
// Testbench for countdown_timer_mmss_display_unit: directed and random event transactions,
// each result checked against a cycle-free model of the timer held in a scoreboard class.
// Depends on cdt_pkg and the countdown timer RTL.
module tb_countdown_timer_mmss_display_unit
    import cdt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int ITEM_TARGET    = 1450;
    localparam int CALM_TAIL      = 250;
    localparam int HOLD_AT_ITEM   = 700;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int KNOB_FULL      = 1023;
    localparam int SECS_PER_MIN   = 60;
    localparam logic PRESSED      = 1'b0;
    localparam logic RELEASED     = 1'b1;

    class timer_scoreboard;
        logic [11:0] secs_left;
        logic        running;
        logic        fresh;
        logic [3:0]  digit_sel;
        logic        lamp;
        logic        sig;
        result_t     pending_results[$];
        int          errors;
        int          n_display, n_second, n_button, n_knob;
        int          n_starts, n_ends, n_loads, n_checked;

        function new();
            secs_left = RESET_TIME;
            running   = 1'b0;
            fresh     = 1'b1;
            digit_sel = SEL_SEC_ONES;
            lamp      = 1'b0;
            sig       = 1'b0;
        endfunction

        function logic [5:0] knob_units(logic [9:0] raw);
            return 6'((32'(raw) * 32'(KNOB_GAIN)) / KNOB_FULL);
        endfunction

        function void note_event(logic [1:0] op, logic level, logic [9:0] m_raw,
                                 logic [9:0] s_raw);
            result_t r;
            int      mins;
            int      secs;
            r = '0;
            case (op)
                OP_DISPLAY:
                begin
                    n_display++;
                    mins = secs_left / SECS_PER_MIN;
                    secs = secs_left % SECS_PER_MIN;
                    case (digit_sel)
                        SEL_SEC_ONES: r.digit_value = 4'(secs % DIGIT_BASE);
                        SEL_SEC_TENS: r.digit_value = 4'(secs / DIGIT_BASE);
                        SEL_MIN_ONES: r.digit_value = 4'(mins % DIGIT_BASE);
                        SEL_MIN_TENS: r.digit_value = 4'(mins / DIGIT_BASE);
                        default:      r.digit_value = 4'd0;
                    endcase
                    r.digit_enable = digit_sel;
                    if (digit_sel == SEL_MIN_TENS)
                        digit_sel = SEL_SEC_ONES;
                    else
                    begin
                        digit_sel = digit_sel << 1;
                        if (digit_sel == 4'd0)
                            digit_sel = SEL_SEC_ONES;
                    end
                end
                OP_SECOND:
                begin
                    n_second++;
                    if (running)
                    begin
                        lamp = ~lamp;
                        if (secs_left > 12'd1)
                            secs_left = secs_left - 12'd1;
                        else
                        begin
                            secs_left = '0;
                            running   = 1'b0;
                            fresh     = 1'b1;
                            sig       = 1'b0;
                            n_ends++;
                        end
                    end
                    else
                        lamp = 1'b0;
                end
                OP_BUTTON:
                begin
                    n_button++;
                    if (level == PRESSED)
                    begin
                        if (!running)
                        begin
                            sig     = 1'b1;
                            running = 1'b1;
                            fresh   = 1'b0;
                            n_starts++;
                        end
                        else
                            running = 1'b0;
                    end
                end
                default:
                begin
                    n_knob++;
                    if (!running && fresh)
                    begin
                        secs_left = 12'(int'(knob_units(m_raw)) * SECS_PER_MIN
                                        + int'(knob_units(s_raw)));
                        n_loads++;
                    end
                end
            endcase
            r.blink       = lamp;
            r.signal_out  = sig;
            r.is_counting = running;
            r.remaining   = secs_left;
            pending_results.push_back(r);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $error("result transaction with no outstanding event");
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            compare("digit_value", want.digit_value, got.digit_value);
            compare("digit_enable", want.digit_enable, got.digit_enable);
            compare("blink", want.blink, got.blink);
            compare("signal_out", want.signal_out, got.signal_out);
            compare("is_counting", want.is_counting, got.is_counting);
            compare("remaining", want.remaining, got.remaining);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic        button_level;
    logic [9:0]  minutes_raw;
    logic [9:0]  seconds_raw;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  digit_value;
    logic [3:0]  digit_enable;
    logic        blink;
    logic        signal_out;
    logic        is_counting;
    logic [11:0] remaining;

    timer_scoreboard sb;
    int              items_sent;
    int              cycle_count;
    bit              idling_on;
    bit              hold_request;

    countdown_timer_mmss_display_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .button_level (button_level),
        .minutes_raw  (minutes_raw),
        .seconds_raw  (seconds_raw),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digit_value  (digit_value),
        .digit_enable (digit_enable),
        .blink        (blink),
        .signal_out   (signal_out),
        .is_counting  (is_counting),
        .remaining    (remaining)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{digit_value, digit_enable, blink, signal_out, is_counting, remaining};
            sb.check_result(got);
        end
    end

    initial
    begin : result_sink
        int gap;
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 19);
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_event(input logic [1:0] op, input logic level,
                              input logic [9:0] m_raw, input logic [9:0] s_raw);
        int gap;
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        button_level <= level;
        minutes_raw  <= m_raw;
        seconds_raw  <= s_raw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_event(op, level, m_raw, s_raw);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_noise_event(input logic [1:0] op);
        send_event(op, 1'($urandom_range(0, 1)), 10'($urandom_range(0, KNOB_FULL)),
                   10'($urandom_range(0, KNOB_FULL)));
    endtask

    task automatic run_countdown_sequence();
        int         len;
        int         pick;
        logic [9:0] m_raw;
        m_raw = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, KNOB_FULL))
                                            : 10'($urandom_range(0, 17));
        send_event(OP_KNOB, 1'($urandom_range(0, 1)), m_raw,
                   10'($urandom_range(0, KNOB_FULL)));
        send_event(OP_BUTTON, PRESSED, 10'($urandom_range(0, KNOB_FULL)),
                   10'($urandom_range(0, KNOB_FULL)));
        if ($urandom_range(0, 1) == 1)
            send_event(OP_BUTTON, RELEASED, 10'($urandom_range(0, KNOB_FULL)),
                       10'($urandom_range(0, KNOB_FULL)));
        len = $urandom_range(5, 40);
        repeat (len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_noise_event(OP_DISPLAY);
            else if (pick < 80)
                send_noise_event(OP_SECOND);
            else if (pick < 92)
                send_noise_event(OP_BUTTON);
            else
                send_noise_event(OP_KNOB);
        end
    endtask

    initial
    begin : stimulus
        bit hold_done;
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_DISPLAY;
        button_level = RELEASED;
        minutes_raw  = '0;
        seconds_raw  = '0;
        idling_on    = 1'b0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // reset time on all four digits, then idle events while stopped
        repeat (4) send_event(OP_DISPLAY, RELEASED, '0, '0);
        send_event(OP_SECOND, RELEASED, '0, '0);
        send_event(OP_BUTTON, RELEASED, '0, '0);
        // full-scale knobs give 59:59
        send_event(OP_KNOB, RELEASED, 10'(KNOB_FULL), 10'(KNOB_FULL));
        repeat (4) send_event(OP_DISPLAY, RELEASED, '0, '0);
        // start at zero ends on the next second
        send_event(OP_KNOB, PRESSED, '0, '0);
        send_event(OP_BUTTON, PRESSED, '0, '0);
        send_event(OP_BUTTON, RELEASED, '0, '0);
        send_event(OP_SECOND, RELEASED, '0, '0);
        // short run with pause, knob while paused and resume
        send_event(OP_KNOB, RELEASED, '0, 10'd52);
        send_event(OP_BUTTON, PRESSED, '0, '0);
        send_event(OP_SECOND, RELEASED, '0, '0);
        send_event(OP_BUTTON, PRESSED, '0, '0);
        send_event(OP_KNOB, RELEASED, 10'(KNOB_FULL), 10'(KNOB_FULL));
        send_event(OP_SECOND, RELEASED, '0, '0);
        send_event(OP_BUTTON, PRESSED, '0, '0);
        send_event(OP_BUTTON, RELEASED, '0, '0);
        send_event(OP_SECOND, RELEASED, '0, '0);
        send_event(OP_DISPLAY, RELEASED, '0, '0);

        while (items_sent < ITEM_TARGET)
        begin
            idling_on = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            if (!hold_done && items_sent >= HOLD_AT_ITEM)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(3, 15)) send_noise_event(2'($urandom_range(0, 3)));
            else
                run_countdown_sequence();
        end
        idling_on = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("events: %0d display, %0d second, %0d button, %0d knob; %0d results checked",
                 sb.n_display, sb.n_second, sb.n_button, sb.n_knob, sb.n_checked);
        $display("timer: %0d starts, %0d countdown ends, %0d knob loads, %0d mismatches",
                 sb.n_starts, sb.n_ends, sb.n_loads, sb.errors);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
